// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers shared by the heightmap query RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk_i edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  `ASSERT_CLK(lbl, (ante) |-> (cons), msg)

`endif

// File: src/hmtq_pkg.sv
// ----------------------------------------------------------------------------
// hmtq_pkg
// Types and constants shared by the heightmap terrain height query block.
// ----------------------------------------------------------------------------
`default_nettype none

package hmtq_pkg;

  // Item kinds carried in tuser
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Configuration register indexes
  localparam logic CFG_ORIGIN_X = 1'b0;
  localparam logic CFG_ORIGIN_Z = 1'b1;

  // Fraction width of the grid coordinate and divider steps per stage
  localparam int FRAC_W    = 16;
  localparam int DIV_STEPS = 4;

  // Barycentric weight of one full unit in Q16
  localparam logic [16:0] W_ONE = 17'h10000;

  // Height scale: (p-128)*80 in Q8 over Q16 weights is 5*S/4096 - 10240
  localparam logic [2:0]  HEIGHT_SCALE  = 3'd5;
  localparam logic [11:0] ROUND_BIAS    = 12'd2048;
  localparam int          HEIGHT_SHIFT  = 12;
  localparam logic [15:0] HEIGHT_OFFSET = 16'd10240;

  // Load fields that ride along the query pipeline
  typedef struct packed {
    logic       cmd;
    logic [7:0] grid_col;
    logic [7:0] grid_row;
    logic [7:0] pixel;
  } side_t;

endpackage

`default_nettype wire

// File: src/hmtq_ram.sv
// ----------------------------------------------------------------------------
// hmtq_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module hmtq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16384,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write one word, read one word into the output register
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: src/hmtq_locate.sv
// ----------------------------------------------------------------------------
// hmtq_locate
// Map a world point to a grid cell and Q16 fractions on both axes: origin
// subtract, scale by GRID_POINTS-1, range check and a pipelined restoring
// divider by TILE_SPAN.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module hmtq_locate
  import hmtq_pkg::*;
#(
  parameter int GRID_POINTS = 256,
  parameter int TILE_SPAN   = 800,
  localparam int AW         = $clog2(GRID_POINTS)
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire side_t              in_side_i,
  input  wire logic signed [31:0] in_world_x_i,
  input  wire logic signed [31:0] in_world_z_i,
  input  wire logic signed [31:0] origin_x_i,
  input  wire logic signed [31:0] origin_z_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output side_t                   out_side_o,
  output logic                    out_outside_o,
  output logic [AW-1:0]           out_cell_x_o,
  output logic [FRAC_W-1:0]       out_frac_x_o,
  output logic [AW-1:0]           out_cell_z_o,
  output logic [FRAC_W-1:0]       out_frac_z_o
);

  // Scaled offset width and quotient width (cell bits over fraction bits)
  localparam int UW  = 32 + AW;
  localparam int QW  = AW + FRAC_W;
  localparam int NDS = (QW + DIV_STEPS - 1) / DIV_STEPS;
  localparam int NST = 3 + NDS;

  localparam logic [AW-1:0] GM1  = AW'(GRID_POINTS - 1);
  localparam logic [15:0]   SPAN = 16'(TILE_SPAN);
  localparam longint        LIM_L = longint'(GRID_POINTS - 1) * 256 * longint'(TILE_SPAN);
  localparam logic [UW-1:0] LIM  = UW'(LIM_L);

  typedef struct packed {
    logic          outside;
    logic [15:0]   rem;
    logic [QW-1:0] bits;
    logic [QW-1:0] quo;
  } div_t;

  logic [NST-1:0] v_q;
  logic [NST-1:0] rdy;
  side_t          side_q [NST];

  logic [1:0][31:0]     world_w;
  logic [1:0][31:0]     orig_w;
  logic [1:0]           outside_w;
  logic [1:0][AW-1:0]   cell_w;
  logic [1:0][FRAC_W-1:0] frac_w;

  assign world_w = {in_world_z_i, in_world_x_i};
  assign orig_w  = {origin_z_i, origin_x_i};

  // Advance a stage when it is empty or the next one advances
  always_comb begin
    rdy[NST-1] = !v_q[NST-1] || out_ready_i;
    for (int k = NST - 2; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign in_ready_o = rdy[0];

  // Valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NST; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // Carry load fields alongside
  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      side_q[0] <= in_side_i;
    end
    for (int k = 1; k < NST; k++) begin
      if (rdy[k]) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  for (genvar a = 0; a < 2; a++) begin : g_axis
    logic [32:0]   t_q;
    logic          neg_q;
    logic [UW-1:0] u_q;
    div_t          dv_q [NDS+1];

    // Stage 0: exact 33-bit offset from the origin
    always_ff @(posedge clk_i) begin
      if (rdy[0]) begin
        t_q <= {world_w[a][31], world_w[a]} - {orig_w[a][31], orig_w[a]};
      end
    end

    // Stage 1: scale by GRID_POINTS-1
    always_ff @(posedge clk_i) begin
      if (rdy[1]) begin
        neg_q <= t_q[32];
        u_q   <= UW'(t_q[31:0]) * UW'(GM1);
      end
    end

    // Stage 2: range check and divider setup (dividend is u shifted up by 8)
    always_ff @(posedge clk_i) begin
      if (rdy[2]) begin
        dv_q[0].outside <= neg_q || (u_q >= LIM);
        dv_q[0].rem     <= 16'(u_q >> (AW + 8));
        dv_q[0].bits    <= {u_q[AW+7:0], 8'h00};
        dv_q[0].quo     <= '0;
      end
    end

    // Divider stages: a few quotient bits each
    for (genvar j = 0; j < NDS; j++) begin : g_div
      div_t dv_d;

      always_comb begin
        div_t        cur;
        logic [16:0] trial;
        cur   = dv_q[j];
        trial = '0;
        for (int s = 0; s < DIV_STEPS; s++) begin
          if (j * DIV_STEPS + s < QW) begin
            trial    = {cur.rem, cur.bits[QW-1]};
            cur.bits = cur.bits << 1;
            if (trial >= {1'b0, SPAN}) begin
              cur.rem = 16'(trial - {1'b0, SPAN});
              cur.quo = {cur.quo[QW-2:0], 1'b1};
            end else begin
              cur.rem = trial[15:0];
              cur.quo = {cur.quo[QW-2:0], 1'b0};
            end
          end
        end
        dv_d = cur;
      end

      always_ff @(posedge clk_i) begin
        if (rdy[3+j]) begin
          dv_q[j+1] <= dv_d;
        end
      end
    end

    assign outside_w[a] = dv_q[NDS].outside;
    assign cell_w[a]    = dv_q[NDS].quo[QW-1:FRAC_W];
    assign frac_w[a]    = dv_q[NDS].quo[FRAC_W-1:0];
  end

  assign out_valid_o   = v_q[NST-1];
  assign out_side_o    = side_q[NST-1];
  assign out_outside_o = outside_w[0] | outside_w[1];
  assign out_cell_x_o  = cell_w[0];
  assign out_frac_x_o  = frac_w[0];
  assign out_cell_z_o  = cell_w[1];
  assign out_frac_z_o  = frac_w[1];

  `ASSERT_IMPL(a_cell_in_grid, out_valid_o && !out_outside_o, (32'(out_cell_x_o) < 32'(GRID_POINTS - 1)) && (32'(out_cell_z_o) < 32'(GRID_POINTS - 1)), "in-range cell beyond last grid cell")

endmodule

`default_nettype wire

// File: src/hmtq_interp.sv
// ----------------------------------------------------------------------------
// hmtq_interp
// Heightmap storage in four parity banks, sample fetch, triangle weights,
// barycentric sum and Q8 height rounding.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module hmtq_interp
  import hmtq_pkg::*;
#(
  parameter int GRID_POINTS = 256,
  localparam int AW         = $clog2(GRID_POINTS)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire side_t             in_side_i,
  input  wire logic              in_outside_i,
  input  wire logic [AW-1:0]     in_cell_x_i,
  input  wire logic [FRAC_W-1:0] in_frac_x_i,
  input  wire logic [AW-1:0]     in_cell_z_i,
  input  wire logic [FRAC_W-1:0] in_frac_z_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [14:0]            out_height_o,
  output logic                   out_in_range_o
);

  // Bank address: half row over half column
  localparam int HAW = (AW > 1) ? AW - 1 : 1;
  localparam int BAW = 2 * HAW;
  localparam int NST = 5;

  logic [NST-1:0] v_q;
  logic [NST-1:0] rdy;

  // Advance a stage when it is empty or the next one advances
  always_comb begin
    rdy[NST-1] = !v_q[NST-1] || out_ready_i;
    for (int k = NST - 2; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign in_ready_o = rdy[0];

  // Stage 0 registers (sample words sit in the bank read registers)
  logic              cmd0_q;
  logic              out0_q;
  logic              px0_q;
  logic              pz0_q;
  logic [FRAC_W-1:0] fx0_q;
  logic [FRAC_W-1:0] fz0_q;

  // Load write decode
  logic [AW-1:0] ld_col;
  logic [AW-1:0] ld_row;
  logic          ld_we;
  logic [AW-1:0] cx1;
  logic [AW-1:0] cz1;
  logic [7:0]    rd [4];

  assign ld_col = AW'(in_side_i.grid_col);
  assign ld_row = AW'(in_side_i.grid_row);
  assign ld_we  = in_valid_i && rdy[0] && (in_side_i.cmd == CMD_LOAD) &&
                  (32'(in_side_i.grid_col) < 32'(GRID_POINTS)) &&
                  (32'(in_side_i.grid_row) < 32'(GRID_POINTS));
  assign cx1    = in_cell_x_i + AW'(1);
  assign cz1    = in_cell_z_i + AW'(1);

  // One bank per row/column parity: each query reads every bank once
  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic PR = 1'(b / 2);
    localparam logic PC = 1'(b % 2);

    logic [AW-1:0]  row_sel;
    logic [AW-1:0]  col_sel;
    logic [BAW-1:0] raddr;
    logic [BAW-1:0] waddr;
    logic           we;

    assign row_sel = (in_cell_z_i[0] == PR) ? in_cell_z_i : cz1;
    assign col_sel = (in_cell_x_i[0] == PC) ? in_cell_x_i : cx1;
    assign raddr   = {HAW'(row_sel >> 1), HAW'(col_sel >> 1)};
    assign waddr   = {HAW'(ld_row >> 1), HAW'(ld_col >> 1)};
    assign we      = ld_we && (ld_row[0] == PR) && (ld_col[0] == PC);

    hmtq_ram #(
      .WIDTH (8),
      .DEPTH (2 ** BAW)
    ) u_bank (
      .clk_i   (clk_i),
      .we_i    (we),
      .waddr_i (waddr),
      .wdata_i (in_side_i.pixel),
      .re_i    (rdy[0]),
      .raddr_i (raddr),
      .rdata_o (rd[b])
    );
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      cmd0_q <= in_side_i.cmd;
      out0_q <= in_outside_i;
      px0_q  <= in_cell_x_i[0];
      pz0_q  <= in_cell_z_i[0];
      fx0_q  <= in_frac_x_i;
      fz0_q  <= in_frac_z_i;
    end
  end

  // Stage 1: route samples, pick the triangle and its weights
  logic [7:0]  h00;
  logic [7:0]  h10;
  logic [7:0]  h01;
  logic [7:0]  h11;
  logic [16:0] fsum;
  logic        upper;
  logic [16:0] w0_d;
  logic [16:0] w1_d;
  logic [16:0] w2_d;
  logic [7:0]  a_d;
  logic [7:0]  b_d;
  logic [7:0]  c_d;

  always_comb begin
    h00   = rd[{pz0_q, px0_q}];
    h10   = rd[{pz0_q, ~px0_q}];
    h01   = rd[{~pz0_q, px0_q}];
    h11   = rd[{~pz0_q, ~px0_q}];
    fsum  = {1'b0, fx0_q} + {1'b0, fz0_q};
    upper = fsum > W_ONE;
    if (upper) begin
      w0_d = W_ONE - {1'b0, fz0_q};
      w1_d = fsum - W_ONE;
      w2_d = W_ONE - {1'b0, fx0_q};
      a_d  = h10;
      b_d  = h11;
      c_d  = h01;
    end else begin
      w0_d = W_ONE - fsum;
      w1_d = {1'b0, fx0_q};
      w2_d = {1'b0, fz0_q};
      a_d  = h00;
      b_d  = h10;
      c_d  = h01;
    end
  end

  logic [16:0] w0_q;
  logic [16:0] w1_q;
  logic [16:0] w2_q;
  logic [7:0]  a_q;
  logic [7:0]  b_q;
  logic [7:0]  c_q;
  logic        out1_q;

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      w0_q   <= w0_d;
      w1_q   <= w1_d;
      w2_q   <= w2_d;
      a_q    <= a_d;
      b_q    <= b_d;
      c_q    <= c_d;
      out1_q <= out0_q;
    end
  end

  // Stage 2: weight times sample
  logic [24:0] p0_q;
  logic [24:0] p1_q;
  logic [24:0] p2_q;
  logic        out2_q;

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      p0_q   <= 25'(w0_q) * 25'(a_q);
      p1_q   <= 25'(w1_q) * 25'(b_q);
      p2_q   <= 25'(w2_q) * 25'(c_q);
      out2_q <= out1_q;
    end
  end

  // Stage 3: sum of the three terms
  logic [25:0] s_q;
  logic        out3_q;

  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      s_q    <= 26'(p0_q) + 26'(p1_q) + 26'(p2_q);
      out3_q <= out2_q;
    end
  end

  // Stage 4: scale, round half up, remove the sample bias, zero off the grid
  logic [26:0] sc;
  logic [15:0] hq;

  assign sc = 27'(s_q) * 27'(HEIGHT_SCALE) + 27'(ROUND_BIAS);
  assign hq = 16'(sc >> HEIGHT_SHIFT) - HEIGHT_OFFSET;

  logic [14:0] height_q;
  logic        in_range_q;

  always_ff @(posedge clk_i) begin
    if (rdy[4]) begin
      height_q   <= out3_q ? 15'd0 : hq[14:0];
      in_range_q <= !out3_q;
    end
  end

  // Valid bits; loads leave the pipeline after the bank write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) begin
        v_q[0] <= in_valid_i;
      end
      if (rdy[1]) begin
        v_q[1] <= v_q[0] && (cmd0_q == CMD_QUERY);
      end
      for (int k = 2; k < NST; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign out_valid_o    = v_q[NST-1];
  assign out_height_o   = height_q;
  assign out_in_range_o = in_range_q;

  `ASSERT_IMPL(a_weights_unity, v_q[1], (18'(w0_q) + 18'(w1_q) + 18'(w2_q)) == 18'(W_ONE), "barycentric weights do not sum to one")

endmodule

`default_nettype wire

// File: src/heightmap_terrain_height_query_top.sv
// ----------------------------------------------------------------------------
// heightmap_terrain_height_query_top: heightmap load and height query stream
// Pipeline depth is set by the four-bit-per-stage cell and fraction divider.
// Throughput one word per cycle unless m_axis_tready stalls the pipeline;
// loads write a parity bank, give no result.
// Reset clears valid bits and origins; samples undefined until loaded.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module heightmap_terrain_height_query_top
  import hmtq_pkg::*;
#(
  parameter int GRID_POINTS = 256,
  parameter int TILE_SPAN   = 800
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration write channel
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  // Input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata: grid_col[7:0], grid_row[15:8], pixel[23:16], world_x[55:24],
  //        world_z[87:56]
  input  wire logic [87:0] s_axis_tdata,
  // tuser: cmd[0]
  input  wire logic        s_axis_tuser,
  // Result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata: height[14:0], in_range[15]
  output logic [15:0]      m_axis_tdata
);

  localparam int AW = $clog2(GRID_POINTS);

  logic signed [31:0] origin_x_q;
  logic signed [31:0] origin_z_q;

  // Hold the tile origin
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q <= '0;
      origin_z_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_ORIGIN_X: origin_x_q <= cfg_data_i;
        CFG_ORIGIN_Z: origin_z_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Unpack the input word
  side_t in_side;

  assign in_side.cmd      = s_axis_tuser;
  assign in_side.grid_col = s_axis_tdata[7:0];
  assign in_side.grid_row = s_axis_tdata[15:8];
  assign in_side.pixel    = s_axis_tdata[23:16];

  logic              loc_valid;
  logic              loc_ready;
  side_t             loc_side;
  logic              loc_outside;
  logic [AW-1:0]     loc_cell_x;
  logic [FRAC_W-1:0] loc_frac_x;
  logic [AW-1:0]     loc_cell_z;
  logic [FRAC_W-1:0] loc_frac_z;
  logic [14:0]       res_height;
  logic              res_in_range;

  hmtq_locate #(
    .GRID_POINTS (GRID_POINTS),
    .TILE_SPAN   (TILE_SPAN)
  ) u_locate (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .in_side_i     (in_side),
    .in_world_x_i  (s_axis_tdata[55:24]),
    .in_world_z_i  (s_axis_tdata[87:56]),
    .origin_x_i    (origin_x_q),
    .origin_z_i    (origin_z_q),
    .out_valid_o   (loc_valid),
    .out_ready_i   (loc_ready),
    .out_side_o    (loc_side),
    .out_outside_o (loc_outside),
    .out_cell_x_o  (loc_cell_x),
    .out_frac_x_o  (loc_frac_x),
    .out_cell_z_o  (loc_cell_z),
    .out_frac_z_o  (loc_frac_z)
  );

  hmtq_interp #(
    .GRID_POINTS (GRID_POINTS)
  ) u_interp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (loc_valid),
    .in_ready_o     (loc_ready),
    .in_side_i      (loc_side),
    .in_outside_i   (loc_outside),
    .in_cell_x_i    (loc_cell_x),
    .in_frac_x_i    (loc_frac_x),
    .in_cell_z_i    (loc_cell_z),
    .in_frac_z_i    (loc_frac_z),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_height_o   (res_height),
    .out_in_range_o (res_in_range)
  );

  // Pack the result word
  assign m_axis_tdata = {res_in_range, res_height};

  `ASSERT_IMPL(a_outside_zero, m_axis_tvalid && !m_axis_tdata[15], m_axis_tdata[14:0] == 15'd0, "point off the grid must give zero height")

endmodule

`default_nettype wire
